// ===== sv/gdsb_pkg.sv =====
// ----------------------------------------------------------------------------
// gdsb_pkg
// Shared types, constants and calendar helpers for the date step-back block.
// ----------------------------------------------------------------------------
package gdsb_pkg;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int CNT_IN_W = 16;

	// year mod 400 via reciprocal: q = (y * 20971) >> 23, low by at most one
	localparam int YEAR_CYCLE   = 400;
	localparam int RECIP_W      = 15;
	localparam int RECIP_SHIFT  = 23;
	localparam int PROD_W       = YEAR_W + RECIP_W;
	localparam int QUOT_W       = PROD_W - RECIP_SHIFT;
	localparam int REM_W        = 10;
	localparam logic [RECIP_W-1:0] RECIP_400 = 15'd20971;

	localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
	localparam logic [DAY_W-1:0]   DAY_MAX   = 5'd31;
	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	typedef struct packed {
		logic [DAY_W-1:0]    in_day;
		logic [MONTH_W-1:0]  in_month;
		logic [YEAR_W-1:0]   in_year;
		logic [CNT_IN_W-1:0] days_back;
	} item_t;

	typedef struct packed {
		logic [DAY_W-1:0]   out_day;
		logic [MONTH_W-1:0] out_month;
		logic [YEAR_W-1:0]  out_year;
		logic               date_valid;
		logic               underflow;
	} result_t;

	typedef struct packed {
		logic load;
		logic rem;
		logic fix;
		logic check;
		logic step;
		logic floor;
	} dp_cmd_t;

	typedef struct packed {
		logic date_ok;
		logic cnt_zero;
		logic at_floor;
	} dp_sts_t;

	function automatic logic [DAY_W-1:0] month_len(logic [MONTH_W-1:0] m, logic leap);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd2:                                      len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			default:                                   len = 5'd0;
		endcase
		return len;
	endfunction

	// ymod is the year mod 400
	function automatic logic leap_of(logic [REM_W-1:0] ymod);
		return (ymod[1:0] == 2'd0) && (ymod != 10'd100) && (ymod != 10'd200)
			&& (ymod != 10'd300);
	endfunction

endpackage

// ===== sv/gdsb_dp.sv =====
// ----------------------------------------------------------------------------
// gdsb_dp
// Datapath: date and count registers, year mod 400 tracking, day step.
// ----------------------------------------------------------------------------
module gdsb_dp #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic             clk,
	input  gdsb_pkg::item_t  item,
	input  gdsb_pkg::dp_cmd_t cmd,
	output gdsb_pkg::dp_sts_t sts,
	output gdsb_pkg::result_t result
);
	import gdsb_pkg::*;

	logic [DAY_W-1:0]       day_q;
	logic [MONTH_W-1:0]     month_q;
	logic [YEAR_W-1:0]      year_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [PROD_W-1:0]      prod_q;
	logic [REM_W-1:0]       rem_q;
	logic                   valid_q;
	logic                   uflow_q;

	logic [QUOT_W-1:0] quot;
	logic              leap;
	logic [DAY_W-1:0]  cur_len;

	assign quot    = prod_q[PROD_W-1:RECIP_SHIFT];
	assign leap    = leap_of(rem_q);
	assign cur_len = month_len(month_q, leap);

	assign sts.date_ok  = (day_q != '0) && (day_q <= cur_len);
	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.at_floor = (day_q == DAY_FIRST) && (month_q == MONTH_JAN) && (year_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			day_q   <= item.in_day;
			month_q <= item.in_month;
			year_q  <= item.in_year;
			cnt_q   <= COUNT_WIDTH'(item.days_back);
			prod_q  <= PROD_W'(item.in_year) * PROD_W'(RECIP_400);
			valid_q <= 1'b0;
			uflow_q <= 1'b0;
		end
		if (cmd.rem) begin
			rem_q <= REM_W'(year_q - YEAR_W'(YEAR_W'(quot) * YEAR_W'(YEAR_CYCLE)));
		end
		if (cmd.fix) begin
			if (rem_q >= REM_W'(YEAR_CYCLE)) begin
				rem_q <= rem_q - REM_W'(YEAR_CYCLE);
			end
		end
		if (cmd.check) begin
			valid_q <= sts.date_ok;
		end
		if (cmd.floor) begin
			uflow_q <= 1'b1;
		end
		if (cmd.step) begin
			cnt_q <= cnt_q - 1'b1;
			if (day_q == DAY_FIRST) begin
				if (month_q == MONTH_JAN) begin
					month_q <= MONTH_DEC;
					year_q  <= year_q - 1'b1;
					rem_q   <= (rem_q == '0) ? REM_W'(YEAR_CYCLE - 1) : rem_q - 1'b1;
					day_q   <= DAY_MAX;
				end else begin
					month_q <= month_q - 1'b1;
					day_q   <= month_len(month_q - 1'b1, leap);
				end
			end else begin
				day_q <= day_q - 1'b1;
			end
		end
	end

	assign result.out_day    = day_q;
	assign result.out_month  = month_q;
	assign result.out_year   = year_q;
	assign result.date_valid = valid_q;
	assign result.underflow  = uflow_q;

endmodule

// ===== sv/gdsb_ctrl.sv =====
// ----------------------------------------------------------------------------
// gdsb_ctrl
// Controller: sequences load, year remainder, date check and day steps.
// ----------------------------------------------------------------------------
module gdsb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  gdsb_pkg::dp_sts_t sts,
	output gdsb_pkg::dp_cmd_t cmd,
	output logic              busy,
	output logic              done
);
	import gdsb_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_REM   = 3'd1;
	localparam logic [2:0] ST_FIX   = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_STEP  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_REM;
				end
			end
			ST_REM: begin
				cmd.rem = 1'b1;
				state_d = ST_FIX;
			end
			ST_FIX: begin
				cmd.fix = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = sts.date_ok ? ST_STEP : ST_DONE;
			end
			ST_STEP: begin
				if (sts.cnt_zero) begin
					state_d = ST_DONE;
				end else if (sts.at_floor) begin
					cmd.floor = 1'b1;
					state_d   = ST_DONE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

// ===== sv/gregorian_date_step_back.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_step_back
// Steps a Gregorian date back by a day count, one day per cycle, with
// date validation and a stop at 1 January of year 0.
//
//   channel   handshake        beat
//   -------   --------------   ----------------------------------
//   item      start, busy      in_day, in_month, in_year, days_back
//   result    done (strobe)    out_day, out_month, out_year,
//                              date_valid, underflow
//
// An item passes from accept through the remainder, fix and check steps
// to the day-step loop in the datapath, one day per cycle, and then to done;
// an invalid date skips the loop, which also stops at 1 January of year 0.
// busy is high from the cycle after accept through the done cycle.
// Reset returns the controller to idle. done lasts one cycle; the receiver
// cannot stall it.
// ----------------------------------------------------------------------------
module gregorian_date_step_back #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  gdsb_pkg::item_t   item,
	output logic              done,
	output gdsb_pkg::result_t result
);
	import gdsb_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	gdsb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	gdsb_dp #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk    (clk),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

`ifndef NO_ASSERTIONS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("controller not idle after done");

	a_invalid_no_uflow: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.date_valid |-> !result.underflow)
		else $error("underflow on invalid date");

	a_uflow_floor: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.underflow |-> result.out_day == DAY_FIRST
			&& result.out_month == MONTH_JAN && result.out_year == '0)
		else $error("underflow away from 1 January year 0");
`endif

endmodule

// ===== verif/gregorian_date_step_back_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gregorian_date_step_back_tb
// Self-checking bench for the date step-back block. Directed dates cover
// validity edges, leap rules, month and year wrap and the year-0 floor.
// Random dates follow, most with small counts, near-zero years with full
// counts, and raw field patterns. Each result is checked against an
// in-bench calendar predictor.
// ----------------------------------------------------------------------------
module gregorian_date_step_back_tb;
	import gdsb_pkg::*;

	localparam int CNT_W    = 16;
	localparam int N_RANDOM = 100;
	localparam int WD_LIMIT = 300000;

	class date_scoreboard;
		int      count_w;
		int      errors;
		result_t due_q[$];

		function new(int width);
			count_w = width;
			errors  = 0;
		endfunction

		static function bit is_leap(int y);
			return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
		endfunction

		static function int days_in(int m, int y);
			case (m)
				2:                      return is_leap(y) ? 29 : 28;
				4, 6, 9, 11:            return 30;
				1, 3, 5, 7, 8, 10, 12:  return 31;
				default:                return 0;
			endcase
		endfunction

		static function bit date_ok(int d, int m, int y);
			return (m >= 1) && (m <= 12) && (d >= 1) && (d <= days_in(m, y));
		endfunction

		function result_t step_back(item_t it);
			int      d;
			int      m;
			int      y;
			longint  n;
			result_t r;
			d = int'(it.in_day);
			m = int'(it.in_month);
			y = int'(it.in_year);
			n = longint'(it.days_back) & ((64'd1 << count_w) - 1);
			r = '0;
			if (date_ok(d, m, y)) begin
				r.date_valid = 1'b1;
				while (n > 0) begin
					if (d == 1 && m == 1 && y == 0) begin
						r.underflow = 1'b1;
						break;
					end
					n--;
					if (d > 1) begin
						d--;
					end else begin
						if (m == 1) begin
							m = 12;
							y--;
						end else begin
							m--;
						end
						d = days_in(m, y);
					end
				end
			end
			r.out_day   = DAY_W'(d);
			r.out_month = MONTH_W'(m);
			r.out_year  = YEAR_W'(y);
			return r;
		endfunction

		function void note_item(item_t it);
			due_q.push_back(step_back(it));
		endfunction

		function int pending();
			return due_q.size();
		endfunction

		task report(string msg);
			$display("%0t ns MISMATCH %s", $time, msg);
			errors++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (due_q.size() == 0) begin
				report($sformatf("unexpected beat %0d/%0d/%0d v%b u%b", got.out_day,
					got.out_month, got.out_year, got.date_valid, got.underflow));
				return;
			end
			want = due_q.pop_front();
			if (got.out_day !== want.out_day || got.out_month !== want.out_month
				|| got.out_year !== want.out_year || got.date_valid !== want.date_valid
				|| got.underflow !== want.underflow) begin
				report($sformatf("got %0d/%0d/%0d v%b u%b, want %0d/%0d/%0d v%b u%b",
					got.out_day, got.out_month, got.out_year, got.date_valid,
					got.underflow, want.out_day, want.out_month, want.out_year,
					want.date_valid, want.underflow));
			end
		endtask
	endclass

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	item_t   item   = '0;
	logic    busy;
	logic    done;
	result_t result;

	date_scoreboard sb;
	int             idle_pct = 11;
	int             wd_cnt   = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	gregorian_date_step_back #(
		.COUNT_WIDTH(CNT_W)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.item  (item),
		.done  (done),
		.result(result)
	);

	// result check, accept tracking and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(result);
			if (start && !busy)
				sb.note_item(item);
			if (done || (start && !busy))
				wd_cnt = 0;
			else
				wd_cnt++;
			if (wd_cnt >= WD_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic send_date(input item_t it);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_dmy(input int d, input int m, input int y, input int n);
		item_t it;
		it.in_day    = DAY_W'(d);
		it.in_month  = MONTH_W'(m);
		it.in_year   = YEAR_W'(y);
		it.days_back = CNT_IN_W'(n);
		send_date(it);
	endtask

	function automatic item_t valid_date(int y_lo, int y_hi, int n_hi);
		item_t it;
		int    m;
		int    y;
		y = int'($urandom_range(y_hi, y_lo));
		m = int'($urandom_range(12, 1));
		it.in_year   = YEAR_W'(y);
		it.in_month  = MONTH_W'(m);
		it.in_day    = DAY_W'($urandom_range(date_scoreboard::days_in(m, y), 1));
		it.days_back = CNT_IN_W'($urandom_range(n_hi, 0));
		return it;
	endfunction

	function automatic item_t edge_date();
		item_t it;
		int    m;
		int    y;
		if ($urandom_range(1))
			y = 100 * int'($urandom_range(163, 0));
		else
			y = int'($urandom_range(16383, 0));
		m = int'($urandom_range(12, 1));
		it.in_year   = YEAR_W'(y);
		it.in_month  = MONTH_W'(m);
		it.in_day    = $urandom_range(1) ? DAY_W'(1)
			: DAY_W'(date_scoreboard::days_in(m, y));
		it.days_back = CNT_IN_W'($urandom_range(3, 0));
		return it;
	endfunction

	function automatic item_t raw_date();
		item_t it;
		it.in_day    = DAY_W'($urandom_range(31, 0));
		it.in_month  = MONTH_W'($urandom_range(15, 0));
		it.in_year   = YEAR_W'($urandom_range(16383, 0));
		it.days_back = CNT_IN_W'($urandom_range(65535, 0));
		// keep valid raw dates short
		if (date_scoreboard::date_ok(int'(it.in_day), int'(it.in_month), int'(it.in_year)))
			it.days_back = CNT_IN_W'($urandom_range(400, 0));
		return it;
	endfunction

	initial begin
		int    r;
		item_t it;
		sb = new(CNT_W);
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		idle_pct = 11;
		send_dmy(15, 6, 2024, 0);
		send_dmy(0, 0, 0, 0);
		send_dmy(31, 15, 16383, 65535);
		send_dmy(0, 5, 2020, 10);
		send_dmy(31, 4, 2021, 3);
		send_dmy(10, 13, 2021, 3);
		send_dmy(29, 2, 1900, 1);
		send_dmy(29, 2, 2000, 1);
		send_dmy(29, 2, 2023, 1);
		send_dmy(1, 3, 2024, 1);
		send_dmy(1, 3, 1900, 1);
		send_dmy(1, 3, 2000, 1);
		send_dmy(1, 5, 2024, 1);
		send_dmy(1, 1, 2000, 1);
		send_dmy(1, 1, 1, 1);
		send_dmy(1, 1, 0, 0);
		send_dmy(1, 1, 0, 1);
		send_dmy(5, 1, 0, 4);
		send_dmy(5, 1, 0, 5);
		send_dmy(31, 12, 16383, 0);
		send_dmy(1, 1, 16383, 366);
		send_dmy(31, 12, 16383, 65535);
		send_dmy(2, 1, 100, 65535);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i < N_RANDOM / 3)
				idle_pct = 11;
			else if (i < 2 * N_RANDOM / 3)
				idle_pct = 79;
			else
				idle_pct = 0;
			r = int'($urandom_range(99));
			if (r < 50)
				it = valid_date(0, 16383, 300);
			else if (r < 60)
				it = valid_date(0, 16383, 3000);
			else if (r < 72)
				it = valid_date(0, 2, 65535);
			else if (r < 80)
				it = edge_date();
			else if (r < 98)
				it = raw_date();
			else
				it = valid_date(0, 16383, 65535);
			send_date(it);
		end
		start <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== files.f =====
sv/gdsb_pkg.sv
sv/gdsb_dp.sv
sv/gdsb_ctrl.sv
sv/gregorian_date_step_back.sv
verif/gregorian_date_step_back_tb.sv
